@@ sv/stis_pkg.sv @@
`default_nettype none

package stis_pkg;

    // Field widths of a transaction
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // Operation codes; the fourth code is a no-op
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic signed [VALUE_W-1:0] value;
    } stis_ctrl_t;

endpackage

`default_nettype wire

@@ sv/stis_if.sv @@
`default_nettype none

// Request channel: one operation per transaction
interface stis_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink   (input valid, input mode, input item_value, output ready);
endinterface

// Response channel: one result per transaction
interface stis_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic       dropped;
    logic [4:0] occupancy;

    modport source (output valid, output hit, output dropped, output occupancy, input ready);
    modport sink   (input valid, input hit, input dropped, input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/sorted_table_insert_delete_search.sv @@
// A result is registered and appears in the cycle after its request transaction.
// Throughput: one transaction per cycle while the response register is empty
// or being taken; each operation finishes in the cycle it is accepted.
// Cycle time is set by the compare-and-OR ripple through the row of cells.
// Reset (rst_n, async, active low) empties the table and the response
// register; entry storage is not cleared.
`default_nettype none

module sorted_table_insert_delete_search #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    stis_req_if.sink  req,
    stis_rsp_if.source rsp
);
    import stis_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      out_valid_reg;
    logic                      hit_reg;
    logic                      dropped_reg;
    logic [OCC_W-1:0]          occ_reg;
    logic                      hit_next;
    logic                      dropped_next;
    logic                      accept;
    logic                      full;
    logic                      is_ins;
    logic                      is_del;
    logic                      is_srch;
    stis_ctrl_t                ctrl;

    logic                      occupied [TABLE_DEPTH];
    logic                      le       [TABLE_DEPTH];
    logic                      seen     [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] entry    [TABLE_DEPTH];

    // Handshake and decode
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign is_ins    = (req.mode == MODE_INSERT);
    assign is_del    = (req.mode == MODE_DELETE);
    assign is_srch   = (req.mode == MODE_SEARCH);

    assign ctrl.ins_en = accept && is_ins && !full;
    assign ctrl.del_en = accept && is_del && seen[TABLE_DEPTH-1];
    assign ctrl.value  = req.item_value;

    // Row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        assign occupied[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            stis_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .left_le     (1'b1),
                .left_seen   (1'b0),
                .left_entry  (req.item_value),
                .right_entry (entry[i+1]),
                .le          (le[i]),
                .seen        (seen[i]),
                .entry       (entry[i])
            );
        end
        else if (i == TABLE_DEPTH - 1)
        begin : g_last
            stis_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .left_le     (le[i-1]),
                .left_seen   (seen[i-1]),
                .left_entry  (entry[i-1]),
                .right_entry (entry[i]),
                .le          (le[i]),
                .seen        (seen[i]),
                .entry       (entry[i])
            );
        end
        else
        begin : g_mid
            stis_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .left_le     (le[i-1]),
                .left_seen   (seen[i-1]),
                .left_entry  (entry[i-1]),
                .right_entry (entry[i+1]),
                .le          (le[i]),
                .seen        (seen[i]),
                .entry       (entry[i])
            );
        end
    end

    // Result and occupancy of this transaction
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.del_en)
        begin
            count_next = count_reg - CW'(1);
        end
        hit_next     = (is_ins && !full) || ((is_del || is_srch) && seen[TABLE_DEPTH-1]);
        dropped_next = is_ins && full;
    end

    // Count and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg     <= hit_next;
            dropped_reg <= dropped_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.dropped   = dropped_reg;
    assign rsp.occupancy = occ_reg;

`ifndef SYNTH
    // A refused insert never reports a hit
    a_drop_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> !hit_reg)
        else $error("dropped and hit both set");

    // Count never exceeds the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("count above depth");

    // An insert into a non-full table grows the count by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_ins && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

    // Search leaves the count alone
    a_srch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_srch) |=> (count_reg == $past(count_reg)))
        else $error("search changed count");
`endif

endmodule

`default_nettype wire

@@ sv/stis_cell.sv @@
`default_nettype none

module stis_cell (
    input  wire logic                               clk,
    input  wire stis_pkg::stis_ctrl_t               ctrl,
    input  wire logic                               occupied,
    input  wire logic                               left_le,
    input  wire logic                               left_seen,
    input  wire logic signed [stis_pkg::VALUE_W-1:0] left_entry,
    input  wire logic signed [stis_pkg::VALUE_W-1:0] right_entry,
    output logic                                    le,
    output logic                                    seen,
    output logic signed [stis_pkg::VALUE_W-1:0]     entry
);
    import stis_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      eq;

    // Compare against the broadcast value
    assign le    = occupied && (entry_reg <= ctrl.value);
    assign eq    = occupied && (entry_reg == ctrl.value);
    // First match seen at or left of this cell
    assign seen  = left_seen || eq;
    assign entry = entry_reg;

    // Insert shifts right from the slot, delete shifts left from the match
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.ins_en && !le)
        begin
            entry_next = left_le ? ctrl.value : left_entry;
        end
        else if (ctrl.del_en && seen)
        begin
            entry_next = right_entry;
        end
        else
        begin
            // no shift through this cell
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/sorted_table_insert_delete_search_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow copy of the sorted table and
// compares each response transaction against the oldest predicted outcome.
module sorted_table_insert_delete_search_checker
    import stis_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    stis_req_if  req,
    stis_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   refused_inserts,
    output int   peak_fill
);

    typedef struct packed {
        logic             hit;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    // Shadow table: entries 0 .. fill-1 are valid, ascending
    logic signed [VALUE_W-1:0] shadow [TABLE_DEPTH];
    int                        fill;
    outcome_t                  pending_q [$];

    // First slot equal to v, or fill when v is absent
    function automatic int locate(input logic signed [VALUE_W-1:0] v);
        int i;
        for (i = 0; i < fill; i++)
        begin
            if (shadow[i] == v)
                return i;
            if (shadow[i] > v)
                break;
        end
        return fill;
    endfunction

    // Apply one operation to the shadow table and form its outcome
    task automatic apply_op(input logic [MODE_W-1:0] m,
                            input logic signed [VALUE_W-1:0] v,
                            output outcome_t r);
        int pos;
        int i;
        r = '0;
        case (m)
            MODE_INSERT:
            begin
                if (fill >= TABLE_DEPTH)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    // equal values stay ahead of the new one
                    pos = 0;
                    while (pos < fill && shadow[pos] <= v)
                        pos++;
                    for (i = fill; i > pos; i--)
                        shadow[i] = shadow[i-1];
                    shadow[pos] = v;
                    fill++;
                    r.hit = 1'b1;
                end
            end
            MODE_DELETE:
            begin
                pos = locate(v);
                if (pos < fill)
                begin
                    for (i = pos; i + 1 < fill; i++)
                        shadow[i] = shadow[i+1];
                    fill--;
                    r.hit = 1'b1;
                end
            end
            MODE_SEARCH:
            begin
                r.hit = (locate(v) < fill);
            end
            default:
            begin
                // unused code: no change, no flags
            end
        endcase
        r.occupancy = fill[OCC_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            fill = 0;
            pending_q.delete();
            mismatches      <= 0;
            outstanding     <= 0;
            refused_inserts <= 0;
            peak_fill       <= 0;
        end
        else
        begin
            // responses first: a response never belongs to a request of this edge
            if (rsp.valid && rsp.ready)
            begin
                got = '{hit: rsp.hit, dropped: rsp.dropped, occupancy: rsp.occupancy};
                if (pending_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: response with nothing pending: hit=%b dropped=%b occ=%0d",
                                 $realtime, got.hit, got.dropped, got.occupancy);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: expected hit=%b dropped=%b occ=%0d, ",
                                      "got hit=%b dropped=%b occ=%0d"},
                                     $realtime, want.hit, want.dropped, want.occupancy,
                                     got.hit, got.dropped, got.occupancy);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            // new request: predict its outcome
            if (req.valid && req.ready)
            begin
                apply_op(req.mode, req.item_value, want);
                pending_q.push_back(want);
                if (want.dropped)
                    refused_inserts <= refused_inserts + 1;
                if (fill > peak_fill)
                    peak_fill <= fill;
            end

            outstanding <= pending_q.size();
        end
    end

endmodule

@@ tb/sv/sorted_table_insert_delete_search_test.sv @@
`timescale 1ns / 100ps

module sorted_table_insert_delete_search_test;

    import stis_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PHASE_ITEMS  = 405;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n;

    stis_req_if req ();
    stis_rsp_if rsp ();

    int mismatches;
    int outstanding;
    int refused_inserts;
    int peak_fill;

    // Stimulus shaping knobs
    int stall_pct;
    int stall_run;
    int insert_pct;
    int delete_pct;
    int op_count [4];
    int idle_cycles;
    logic signed [VALUE_W-1:0] value_pool [8];

    sorted_table_insert_delete_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    sorted_table_insert_delete_search_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .rsp            (rsp),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .refused_inserts(refused_inserts),
        .peak_fill      (peak_fill)
    );

    always #1 clk = ~clk;

    // Response side: random stall runs with ready held low
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_run = 0;
            rsp.ready <= 1'b0;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            rsp.ready <= 1'b0;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_run = $urandom_range(15);
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // Present one request and hold it until it is taken
    task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v);
        logic taken;
        req.valid      <= 1'b1;
        req.mode       <= m;
        req.item_value <= v;
        op_count[m]++;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end
    endtask

    // Hold off the sender until every result is back
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Values mostly from a small pool so deletes and searches find matches
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4, 5, 6:
                     return value_pool[$urandom_range(7)];
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return MODE_NOP;
        else if (r < 2 + insert_pct)
            return MODE_INSERT;
        else if (r < 2 + insert_pct + delete_pct)
            return MODE_DELETE;
        else
            return MODE_SEARCH;
    endfunction

    initial
    begin
        int phase;
        int n;
        int burst_left;
        logic gaps_on;

        clk            = 1'b0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = MODE_INSERT;
        req.item_value = '0;
        rsp.ready      = 1'b0;
        stall_pct      = 0;
        stall_run      = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        op_count       = '{default: 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, duplicates, absent values, no-op
        send_op(MODE_SEARCH, VAL_MIN);
        send_op(MODE_DELETE, VAL_MAX);
        send_op(MODE_INSERT, VAL_MAX);
        send_op(MODE_INSERT, VAL_MIN);
        send_op(MODE_INSERT, 32'sd0);
        send_op(MODE_INSERT, 32'sd0);
        send_op(MODE_INSERT, -32'sd1);
        send_op(MODE_SEARCH, 32'sd1);
        send_op(MODE_DELETE, 32'sd0);
        send_op(MODE_SEARCH, 32'sd0);
        send_op(MODE_DELETE, 32'sd7);
        send_op(MODE_NOP, VAL_MAX);
        // fill to capacity, then one insert too many
        for (n = 0; n < TABLE_DEPTH - 4; n++)
            send_op(MODE_INSERT, (n % 2) ? VAL_MAX : 32'sd100 - n);
        send_op(MODE_INSERT, 32'sd5);
        send_op(MODE_DELETE, VAL_MAX);
        send_op(MODE_DELETE, VAL_MIN);
        drain();

        // Random phases: fill-heavy, mixed, drain-heavy, mixed
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin insert_pct = 65; delete_pct = 15; stall_pct = 0;  gaps_on = 0; end
                1:       begin insert_pct = 40; delete_pct = 30; stall_pct = 25; gaps_on = 1; end
                2:       begin insert_pct = 20; delete_pct = 60; stall_pct = 60; gaps_on = 1; end
                default: begin insert_pct = 45; delete_pct = 35; stall_pct = 10; gaps_on = 1; end
            endcase
            value_pool[0] = 32'sd0;
            value_pool[1] = -32'sd1;
            for (n = 2; n < 8; n++)
                value_pool[n] = $urandom;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_op(pick_mode(), pick_value());
                if (gaps_on)
                begin
                    if (burst_left == 0)
                    begin
                        req.valid <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                        burst_left = $urandom_range(1, 20);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            if (phase == 0)
                drain();
        end

        drain();
        repeat (4) @(posedge clk);

        $display("covered %0d inserts, %0d deletes, %0d searches, %0d unused-code requests",
                 op_count[MODE_INSERT], op_count[MODE_DELETE], op_count[MODE_SEARCH],
                 op_count[MODE_NOP]);
        $display("%0d inserts refused on a full table, peak fill %0d of %0d",
                 refused_inserts, peak_fill, TABLE_DEPTH);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
